>>> hw/rtl/fpsd_pkg.sv
// fpsd_pkg: shared types and constants of the fixed-point saturating divider
// no dependencies; compiled first

package fpsd_pkg;

    localparam int WORD_W         = 32;
    // a quotient that passes the overflow guard is always below 2^30
    localparam int QUOT_BITS      = 30;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = (QUOT_BITS + BITS_PER_STAGE - 1) / BITS_PER_STAGE;

    localparam logic [WORD_W-1:0] MOST_POSITIVE = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] MOST_NEGATIVE = 32'h8000_0000;

    typedef logic signed [WORD_W-1:0] fixed_t;
    typedef logic [WORD_W-1:0]        mag_t;
    typedef logic [QUOT_BITS-1:0]     quot_t;

    // one item in flight through the divide stages
    typedef struct packed {
        logic  sat;    // guard fired, division result ignored
        logic  neg;    // operand signs differ
        mag_t  rem;    // partial remainder, below dvsr unless sat is set
        mag_t  dvsr;   // divisor magnitude
        quot_t num;    // numerator bits still to shift in, msb first
        quot_t quot;   // quotient bits produced so far
    } work_t;

endpackage

>>> hw/rtl/fpsd_op_if.sv
// fpsd_op_if: operand channel of the divider (valid/ready plus dividend, divisor)
// depends on fpsd_pkg

interface fpsd_op_if;
    import fpsd_pkg::*;

    logic   valid;
    logic   ready;
    fixed_t dividend;
    fixed_t divisor;

    modport source (output valid, output dividend, output divisor, input ready);
    modport sink (input valid, input dividend, input divisor, output ready);
endinterface

>>> hw/rtl/fpsd_res_if.sv
// fpsd_res_if: result channel of the divider (valid/ready plus quotient, saturated)
// depends on fpsd_pkg

interface fpsd_res_if;
    import fpsd_pkg::*;

    logic   valid;
    logic   ready;
    fixed_t quotient;
    logic   saturated;

    modport source (output valid, output quotient, output saturated, input ready);
    modport sink (input valid, input quotient, input saturated, output ready);
endinterface

>>> hw/rtl/fpsd_div_stage.sv
// fpsd_div_stage: one registered stage of the restoring divider, BITS_PER_STAGE (2) quotient bits
// depends on fpsd_pkg

module fpsd_div_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  logic            in_valid,
    input  fpsd_pkg::work_t in_work,
    output logic            out_valid,
    output fpsd_pkg::work_t out_work
);
    import fpsd_pkg::*;

    logic  valid_reg;
    work_t work_reg;
    work_t work_next;

    always_comb
    begin
        logic [WORD_W:0] trial;
        logic            ge;
        work_next = in_work;
        for (int j = 0; j < BITS_PER_STAGE; j++)
        begin
            trial = {work_next.rem, work_next.num[QUOT_BITS-1]};
            ge    = (trial >= {1'b0, work_next.dvsr});
            if (ge)
            begin
                trial = trial - {1'b0, work_next.dvsr};
            end
            work_next.rem  = trial[WORD_W-1:0];
            work_next.quot = {work_next.quot[QUOT_BITS-2:0], ge};
            work_next.num  = {work_next.num[QUOT_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            work_reg <= work_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_work  = work_reg;

endmodule

>>> hw/rtl/fixed_point_saturating_divide.sv
// fixed_point_saturating_divide: pipelined signed fixed-point divider with overflow guard
// depends on fpsd_pkg, fpsd_op_if, fpsd_res_if, fpsd_div_stage
//
//   channel    dir   transfer carries
//   operands   in    dividend (s32 fixed), divisor (s32 fixed)
//   result     out   quotient (s32 fixed), saturated (1 bit)
//
// one operand transfer per cycle sustained while result is ready; the path is a front stage
// (magnitudes and guard), 15 divide stages of 2 restoring steps each, an output register
// rst_n clears only the stage valid bits; payload registers are not reset
// every stage holds its item until the next stage frees up, so stalls on result
// back up stage by stage and bubbles collapse; nothing is dropped or repeated

module fixed_point_saturating_divide #(
    parameter int FRACTION_BITS = 16
) (
    input logic clk,
    input logic rst_n,
    fpsd_op_if.sink    operands,
    fpsd_res_if.source result
);
    import fpsd_pkg::*;

    // magnitude shift that still leaves a quotient below 2^QUOT_BITS
    localparam int GUARD_SHIFT = QUOT_BITS - FRACTION_BITS;
    localparam int NUM_W       = QUOT_BITS + WORD_W;

    // front stage: magnitudes, sign, guard compare
    logic          front_valid_reg;
    work_t         front_work_reg;
    work_t         front_work_next;
    logic          front_load;

    mag_t              mag_a;
    mag_t              mag_b;
    logic [NUM_W-1:0]  num_full;

    always_comb
    begin
        mag_a    = operands.dividend[WORD_W-1] ? (~operands.dividend + 1'b1)
                                               : operands.dividend;
        mag_b    = operands.divisor[WORD_W-1] ? (~operands.divisor + 1'b1)
                                              : operands.divisor;
        num_full = {{QUOT_BITS{1'b0}}, mag_a} << FRACTION_BITS;

        front_work_next.sat  = ((mag_a >> GUARD_SHIFT) >= mag_b);  // zero divisor lands here
        front_work_next.neg  = operands.dividend[WORD_W-1] ^ operands.divisor[WORD_W-1];
        // unless the guard fires, the high part of the shifted numerator is already below the divisor
        front_work_next.rem  = mag_a >> GUARD_SHIFT;
        front_work_next.dvsr = mag_b;
        front_work_next.num  = num_full[QUOT_BITS-1:0];
        front_work_next.quot = '0;
    end

    // divide stage chain; index 0 is the front stage output
    logic  stage_valid [0:DIV_STAGES];
    work_t stage_work  [0:DIV_STAGES];
    logic  stage_load  [1:DIV_STAGES];

    // output register
    logic   out_valid_reg;
    fixed_t quotient_reg;
    fixed_t quotient_next;
    logic   saturated_reg;
    logic   out_load;

    // ready ripples back: a stage loads when it is empty or its item moves on
    assign out_load   = !out_valid_reg || result.ready;

    generate
        for (genvar s = 1; s <= DIV_STAGES; s++)
        begin : g_div
            if (s == DIV_STAGES)
            begin : g_last
                assign stage_load[s] = !stage_valid[s] || out_load;
            end
            else
            begin : g_mid
                assign stage_load[s] = !stage_valid[s] || stage_load[s+1];
            end

            fpsd_div_stage u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .load      (stage_load[s]),
                .in_valid  (stage_valid[s-1]),
                .in_work   (stage_work[s-1]),
                .out_valid (stage_valid[s]),
                .out_work  (stage_work[s])
            );
        end
    endgenerate

    assign front_load      = !front_valid_reg || stage_load[1];
    assign operands.ready  = front_load;
    assign stage_valid[0]  = front_valid_reg;
    assign stage_work[0]   = front_work_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (front_load)
        begin
            front_valid_reg <= operands.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_load && operands.valid)
        begin
            front_work_reg <= front_work_next;
        end
    end

    // sign fix-up and saturation select; negating a zero quotient stays zero
    always_comb
    begin
        if (stage_work[DIV_STAGES].sat)
        begin
            quotient_next = stage_work[DIV_STAGES].neg ? MOST_NEGATIVE : MOST_POSITIVE;
        end
        else if (stage_work[DIV_STAGES].neg)
        begin
            quotient_next = -fixed_t'({{(WORD_W-QUOT_BITS){1'b0}},
                                       stage_work[DIV_STAGES].quot});
        end
        else
        begin
            quotient_next = fixed_t'({{(WORD_W-QUOT_BITS){1'b0}},
                                      stage_work[DIV_STAGES].quot});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= stage_valid[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && stage_valid[DIV_STAGES])
        begin
            quotient_reg  <= quotient_next;
            saturated_reg <= stage_work[DIV_STAGES].sat;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.quotient  = quotient_reg;
    assign result.saturated = saturated_reg;

endmodule
